// ===== rtl/qet_pkg.sv =====
// qet_pkg: shared types, constants and the quadrature table for the encoder tracker.
// No dependencies; every rtl file imports it.
`default_nettype none
package qet_pkg;

  localparam int unsigned NUM_ENCODERS = 8;
  localparam int unsigned ENC_IDX_W    = 3;
  localparam int unsigned PADDR_W      = 5;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    REG_SWAP    = 3'd0,
    REG_SAMPLES = 3'd1,
    REG_TURN    = 3'd2,
    REG_LSTEP   = 3'd3,
    REG_THRESH  = 3'd4,
    REG_HOLD    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        swap_channels;
    logic [7:0]  samples_until_valid;
    logic [15:0] steps_per_turn;
    logic [15:0] logical_step;
    logic [6:0]  direction_threshold;
    logic [15:0] direction_hold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    dir_t        pending_step;
    logic [7:0]  filter_countdown;
    logic [15:0] direction_countdown;
    dir_t        direction_latched;
    logic [7:0]  net_steps;
    logic [15:0] position_physical;
    logic [15:0] position_logical;
  } enc_state_t;

  // entry[5:4]: emit (01 CW, 10 CCW), entry[1:0]: next phase
  localparam logic [5:0] QUAD_TABLE [16] = '{
    6'h00, 6'h11, 6'h22, 6'h03,
    6'h20, 6'h01, 6'h02, 6'h13,
    6'h10, 6'h01, 6'h02, 6'h23,
    6'h00, 6'h21, 6'h12, 6'h03
  };

endpackage
`default_nettype wire

// ===== rtl/qet_cfg.sv =====
// qet_cfg: APB register file holding the tracker configuration.
// Depends on qet_pkg.
`default_nettype none
module qet_cfg
  import qet_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_channels       <= 1'b0;
      cfg.samples_until_valid <= 8'd4;
      cfg.steps_per_turn      <= 16'd24;
      cfg.logical_step        <= 16'd1;
      cfg.direction_threshold <= 7'd1;
      cfg.direction_hold      <= 16'd100;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SWAP:    cfg.swap_channels       <= pwdata[0];
        REG_SAMPLES: cfg.samples_until_valid <= pwdata[7:0];
        REG_TURN:    cfg.steps_per_turn      <= pwdata[15:0];
        REG_LSTEP:   cfg.logical_step        <= pwdata[15:0];
        REG_THRESH:  cfg.direction_threshold <= pwdata[6:0];
        REG_HOLD:    cfg.direction_hold      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SWAP:    prdata = {31'd0, cfg.swap_channels};
      REG_SAMPLES: prdata = {24'd0, cfg.samples_until_valid};
      REG_TURN:    prdata = {16'd0, cfg.steps_per_turn};
      REG_LSTEP:   prdata = {16'd0, cfg.logical_step};
      REG_THRESH:  prdata = {25'd0, cfg.direction_threshold};
      REG_HOLD:    prdata = {16'd0, cfg.direction_hold};
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/qet_update.sv =====
// qet_update: one poll tick for one encoder: decode, step filter, position and direction.
// Pure combinational; depends on qet_pkg.
`default_nettype none
module qet_update
  import qet_pkg::*;
(
  input  wire cfg_t       cfg,
  input  wire enc_state_t cur,
  input  wire logic       pin_a,
  input  wire logic       pin_b,
  output enc_state_t      nxt,
  output dir_t            step
);

  always_comb begin
    logic [1:0]        pins;
    logic [5:0]        entry;
    dir_t              emit_dir;
    logic [15:0]       p;
    logic signed [8:0] delta;
    logic signed [8:0] thr;

    pins     = cfg.swap_channels ? {pin_a, pin_b} : {pin_b, pin_a};
    entry    = QUAD_TABLE[{cur.phase, pins}];
    emit_dir = entry[5] ? DIR_CCW : DIR_CW;
    thr      = $signed({2'b00, cfg.direction_threshold});
    p        = cur.position_physical;
    delta    = $signed({cur.net_steps[7], cur.net_steps});
    nxt      = cur;
    step     = DIR_NONE;

    if (cur.filter_countdown != 8'd0) nxt.filter_countdown = cur.filter_countdown - 8'd1;
    if (cur.direction_countdown != 16'd0) begin
      nxt.direction_countdown = cur.direction_countdown - 16'd1;
    end else begin
      nxt.direction_latched = DIR_NONE;
    end

    nxt.phase = entry[1:0];

    if (entry[5:4] != 2'b00) begin
      if (cur.pending_step == DIR_NONE) begin
        nxt.pending_step     = emit_dir;
        nxt.filter_countdown = cfg.samples_until_valid;
      end else if (cur.pending_step == emit_dir) begin
        nxt.filter_countdown = cfg.samples_until_valid;
        step                 = emit_dir;
      end else begin
        nxt.pending_step     = DIR_NONE;
        nxt.filter_countdown = 8'd0;
      end
    end else if (cur.pending_step != DIR_NONE && nxt.filter_countdown == 8'd0) begin
      step             = cur.pending_step;
      nxt.pending_step = DIR_NONE;
    end

    if (step == DIR_CCW) begin
      p = cur.position_physical - 16'd1;
      if (p >= cfg.steps_per_turn) p = cfg.steps_per_turn - 16'd1;
      nxt.position_logical = cur.position_logical - cfg.logical_step;
      delta = delta - 9'sd1;
      if (delta <= -thr) begin
        delta                   = 9'sd0;
        nxt.direction_latched   = DIR_CCW;
        nxt.direction_countdown = cfg.direction_hold;
      end
    end else if (step == DIR_CW) begin
      p = cur.position_physical + 16'd1;
      if (p >= cfg.steps_per_turn) p = 16'd0;
      nxt.position_logical = cur.position_logical + cfg.logical_step;
      delta = delta + 9'sd1;
      if (delta >= thr) begin
        delta                   = 9'sd0;
        nxt.direction_latched   = DIR_CW;
        nxt.direction_countdown = cfg.direction_hold;
      end
    end
    nxt.net_steps         = delta[7:0];
    nxt.position_physical = p;
  end

endmodule
`default_nettype wire

// ===== rtl/quadrature_encoder_tracker.sv =====
// quadrature_encoder_tracker: top level; input register, per-encoder state, result register.
// Depends on qet_pkg, qet_cfg, qet_update.
//
//  channel  direction  handshake                     payload
//  tick     in         tick_valid / tick_stall       encoder_index, pin_a, pin_b
//  result   out        result_valid / result_stall   encoder_echo, step_taken,
//                                                    physical_position, logical_position,
//                                                    direction_now
//  config   in         APB psel/penable/pready       paddr, pwdata, prdata
//
// One word per cycle while result_stall is low; an accepted tick passes the tick register, then the result register.
// The tick register feeds the per-encoder update and the result register in one pass;
// state is written at the same edge, so a tick for the same encoder follows directly.
// Reset clears all encoder state and loads the register defaults; no clearing pass.
// A stalled result holds the result register; the tick register still fills behind it.
`default_nettype none
module quadrature_encoder_tracker
  import qet_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 tick_valid,
  output logic                      tick_stall,
  input  wire logic [ENC_IDX_W-1:0] encoder_index,
  input  wire logic                 pin_a,
  input  wire logic                 pin_b,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [ENC_IDX_W-1:0]      encoder_echo,
  output logic [1:0]                step_taken,
  output logic [15:0]               physical_position,
  output logic [15:0]               logical_position,
  output logic [1:0]                direction_now,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  cfg_t                 cfg;
  enc_state_t           enc_state [NUM_ENCODERS];
  enc_state_t           cur;
  enc_state_t           nxt;
  dir_t                 step;
  logic                 s_vld;
  logic [ENC_IDX_W-1:0] s_index;
  logic                 s_a;
  logic                 s_b;
  logic                 s_idx_ok;
  logic                 adv;
  logic                 fire;

  qet_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cur      = enc_state[s_index];
  assign s_idx_ok = (32'(s_index) < NUM_ENCODERS);

  qet_update u_update (
    .cfg   (cfg),
    .cur   (cur),
    .pin_a (s_a),
    .pin_b (s_b),
    .nxt   (nxt),
    .step  (step)
  );

  assign adv        = !result_valid || !result_stall;
  assign fire       = s_vld && adv;
  assign tick_stall = s_vld && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (!tick_stall) begin
      s_vld <= tick_valid;
    end
    if (tick_valid && !tick_stall) begin
      s_index <= encoder_index;
      s_a     <= pin_a;
      s_b     <= pin_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENCODERS; i++) enc_state[i] <= '0;
    end else if (fire && s_idx_ok) begin
      enc_state[s_index] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s_vld;
    end
    if (fire) begin
      encoder_echo <= s_index;
      if (s_idx_ok) begin
        step_taken        <= step;
        physical_position <= nxt.position_physical;
        logical_position  <= nxt.position_logical;
        direction_now     <= nxt.direction_latched;
      end else begin
        step_taken        <= DIR_NONE;
        physical_position <= 16'd0;
        logical_position  <= 16'd0;
        direction_now     <= DIR_NONE;
      end
    end
  end

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (s_vld && result_valid && result_stall))
    else $error("tick stalled without result backpressure");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> (result_valid && encoder_echo == $past(s_index)))
    else $error("tick word did not reach result register");

  a_codes_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (step_taken != 2'd3 && direction_now != 2'd3))
    else $error("illegal direction code on result");

  a_phys_in_range: assert property (@(posedge clk) disable iff (rst)
    (s_vld && step != DIR_NONE && cfg.steps_per_turn != 16'd0)
      |-> (nxt.position_physical < cfg.steps_per_turn))
    else $error("physical position out of turn range after step");

endmodule
`default_nettype wire

// ===== test/tb_quadrature_encoder_tracker.sv =====
// tb_quadrature_encoder_tracker: self-checking testbench for the quadrature encoder tracker.
// Drives pin sample ticks and APB register writes, and checks every result word against a
// scoreboard that models the per-encoder state. Depends on qet_pkg and the tracker RTL.
module tb_quadrature_encoder_tracker;
  import qet_pkg::*;

  typedef struct {
    logic [ENC_IDX_W-1:0] echo;
    logic [1:0]           step;
    logic [15:0]          phys;
    logic [15:0]          logi;
    logic [1:0]           dir;
  } tick_result_t;

  class tracker_scoreboard;
    tick_result_t expected_q[$];
    logic         swap;
    logic [7:0]   samples;
    logic [15:0]  turn;
    logic [15:0]  lstep;
    logic [6:0]   thr;
    logic [15:0]  hold;
    logic [1:0]   phase   [NUM_ENCODERS];
    dir_t         pending [NUM_ENCODERS];
    logic [7:0]   filt    [NUM_ENCODERS];
    logic [15:0]  dcount  [NUM_ENCODERS];
    dir_t         latched [NUM_ENCODERS];
    logic [7:0]   net     [NUM_ENCODERS];
    logic [15:0]  phys    [NUM_ENCODERS];
    logic [15:0]  logi    [NUM_ENCODERS];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      swap = 1'b0;
      samples = 8'd4;
      turn = 16'd24;
      lstep = 16'd1;
      thr = 7'd1;
      hold = 16'd100;
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        phase[i] = '0;
        pending[i] = DIR_NONE;
        filt[i] = '0;
        dcount[i] = '0;
        latched[i] = DIR_NONE;
        net[i] = '0;
        phys[i] = '0;
        logi[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_SWAP:    swap = value[0];
        REG_SAMPLES: samples = value[7:0];
        REG_TURN:    turn = value[15:0];
        REG_LSTEP:   lstep = value[15:0];
        REG_THRESH:  thr = value[6:0];
        REG_HOLD:    hold = value[15:0];
        default: ;
      endcase
    endfunction

    // next phase in [1:0], emit in [5:4] (01 cw, 10 ccw)
    function logic [5:0] quad_entry(logic [3:0] code);
      case (code)
        4'd0:  return 6'h00;
        4'd1:  return 6'h11;
        4'd2:  return 6'h22;
        4'd3:  return 6'h03;
        4'd4:  return 6'h20;
        4'd5:  return 6'h01;
        4'd6:  return 6'h02;
        4'd7:  return 6'h13;
        4'd8:  return 6'h10;
        4'd9:  return 6'h01;
        4'd10: return 6'h02;
        4'd11: return 6'h23;
        4'd12: return 6'h00;
        4'd13: return 6'h21;
        4'd14: return 6'h12;
        default: return 6'h03;
      endcase
    endfunction

    function void note_tick(logic [ENC_IDX_W-1:0] e, logic a, logic b);
      tick_result_t want;
      logic [3:0]   code;
      logic [5:0]   entry;
      dir_t         emit;
      dir_t         step;
      logic [15:0]  p;
      int           delta;
      want.echo = e;
      want.step = DIR_NONE;
      want.phys = '0;
      want.logi = '0;
      want.dir = DIR_NONE;
      step = DIR_NONE;
      if (int'(e) < NUM_ENCODERS) begin
        if (filt[e] != 0) filt[e] = filt[e] - 8'd1;
        if (dcount[e] != 0) dcount[e] = dcount[e] - 16'd1;
        else latched[e] = DIR_NONE;
        code = swap ? {phase[e], a, b} : {phase[e], b, a};
        entry = quad_entry(code);
        phase[e] = entry[1:0];
        emit = entry[5] ? DIR_CCW : (entry[4] ? DIR_CW : DIR_NONE);
        if (emit != DIR_NONE) begin
          if (pending[e] == DIR_NONE) begin
            pending[e] = emit;
            filt[e] = samples;
          end else if (pending[e] == emit) begin
            filt[e] = samples;
            step = emit;
          end else begin
            pending[e] = DIR_NONE;
            filt[e] = '0;
          end
        end else if (pending[e] != DIR_NONE && filt[e] == 0) begin
          step = pending[e];
          pending[e] = DIR_NONE;
        end
        if (step != DIR_NONE) begin
          delta = int'($signed(net[e]));
          if (step == DIR_CCW) begin
            p = phys[e] - 16'd1;
            if (p >= turn) p = turn - 16'd1;
            logi[e] = logi[e] - lstep;
            delta = delta - 1;
            if (delta <= -int'(thr)) begin
              delta = 0;
              latched[e] = DIR_CCW;
              dcount[e] = hold;
            end
          end else begin
            p = phys[e] + 16'd1;
            if (p >= turn) p = '0;
            logi[e] = logi[e] + lstep;
            delta = delta + 1;
            if (delta >= int'(thr)) begin
              delta = 0;
              latched[e] = DIR_CW;
              dcount[e] = hold;
            end
          end
          net[e] = delta[7:0];
          phys[e] = p;
        end
        want.step = step;
        want.phys = phys[e];
        want.logi = logi[e];
        want.dir = latched[e];
      end
      expected_q.push_back(want);
    endfunction

    function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      bit           ok;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: encoder_echo %0d", got.echo);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      ok = field_ok("encoder_echo", 16'(want.echo), 16'(got.echo));
      ok = field_ok("step_taken", 16'(want.step), 16'(got.step)) && ok;
      ok = field_ok("physical_position", want.phys, got.phys) && ok;
      ok = field_ok("logical_position", want.logi, got.logi) && ok;
      ok = field_ok("direction_now", 16'(want.dir), 16'(got.dir)) && ok;
      if (!ok) mismatches++;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 tick_valid = 1'b0;
  logic                 tick_stall;
  logic [ENC_IDX_W-1:0] encoder_index = '0;
  logic                 pin_a = 1'b0;
  logic                 pin_b = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ENC_IDX_W-1:0] encoder_echo;
  logic [1:0]           step_taken;
  logic [15:0]          physical_position;
  logic [15:0]          logical_position;
  logic [1:0]           direction_now;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  tracker_scoreboard board = new();

  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 1;
  logic [1:0]  gray_pos [NUM_ENCODERS];
  bit          spin_ccw [NUM_ENCODERS];

  quadrature_encoder_tracker DUT (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .encoder_index(encoder_index),
    .pin_a(pin_a),
    .pin_b(pin_b),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .encoder_echo(encoder_echo),
    .step_taken(step_taken),
    .physical_position(physical_position),
    .logical_position(logical_position),
    .direction_now(direction_now),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("FAIL quadrature_encoder_tracker");
    $finish;
  end

  initial begin : result_sink
    tick_result_t got;
    int           hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        got.echo = encoder_echo;
        got.step = step_taken;
        got.phys = physical_position;
        got.logi = logical_position;
        got.dir = direction_now;
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  task automatic send_tick(input logic [ENC_IDX_W-1:0] e, input logic a, input logic b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 20) begin
        tick_valid <= 1'b0;
        @(posedge clk);
      end
    end
    tick_valid <= 1'b1;
    encoder_index <= e;
    pin_a <= a;
    pin_b <= b;
    do @(posedge clk); while (tick_stall);
    board.note_tick(e, a, b);
    gray_pos[e] = {b, a ^ b};
    ticks_sent++;
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
  endtask

  task automatic configure(input int unsigned swap, input int unsigned samples,
                           input int unsigned turn, input int unsigned lstep,
                           input int unsigned thr, input int unsigned hold);
    drain();
    write_reg(REG_SWAP, swap);
    write_reg(REG_SAMPLES, samples);
    write_reg(REG_TURN, turn);
    write_reg(REG_LSTEP, lstep);
    write_reg(REG_THRESH, thr);
    write_reg(REG_HOLD, hold);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  // mostly clean gray-code rotation per encoder, with dwell, reversals and pin noise
  task automatic run_random(input int unsigned count, input int unsigned calm_items);
    logic [ENC_IDX_W-1:0] e;
    logic [1:0]           g;
    logic                 a;
    logic                 b;
    int unsigned          roll;
    e = '0;
    for (int unsigned k = 0; k < count; k++) begin
      calm = (k < calm_items);
      if ($urandom_range(0, 99) >= 60) e = ENC_IDX_W'($urandom_range(0, NUM_ENCODERS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        a = 1'($urandom_range(0, 1));
        b = 1'($urandom_range(0, 1));
      end else begin
        g = gray_pos[e];
        if (roll >= 40) begin
          if (roll >= 96) spin_ccw[e] = !spin_ccw[e];
          g = spin_ccw[e] ? g - 2'd1 : g + 2'd1;
        end
        b = g[1];
        a = g[1] ^ g[0];
      end
      send_tick(e, a, b);
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      gray_pos[i] = '0;
      spin_ccw[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: cw steps, timeout acceptance, ccw wrap from zero, cancel, bad jump
    send_tick(3'd0, 1'b1, 1'b0);
    send_tick(3'd0, 1'b1, 1'b1);
    send_tick(3'd0, 1'b0, 1'b1);
    send_tick(3'd0, 1'b0, 1'b0);
    repeat (5) send_tick(3'd0, 1'b0, 1'b0);
    send_tick(3'd1, 1'b0, 1'b1);
    send_tick(3'd1, 1'b1, 1'b1);
    send_tick(3'd1, 1'b0, 1'b1);
    send_tick(3'd2, 1'b1, 1'b1);
    send_tick(3'd7, 1'b1, 1'b0);
    send_tick(3'd7, 1'b0, 1'b1);

    // swapped pins, zero turn size, zero threshold, zero filter, zero hold
    configure(1, 0, 0, 16'hFFFF, 0, 0);
    send_tick(3'd3, 1'b0, 1'b1);
    send_tick(3'd3, 1'b0, 1'b1);
    send_tick(3'd3, 1'b0, 1'b0);
    send_tick(3'd4, 1'b1, 1'b0);
    send_tick(3'd4, 1'b1, 1'b0);
    send_tick(3'd4, 1'b1, 1'b1);
    send_tick(3'd4, 1'b1, 1'b1);
    send_tick(3'd5, 1'b1, 1'b1);
    send_tick(3'd5, 1'b0, 1'b0);

    configure(0, 0, 1, 0, 127, 16'hFFFF);
    run_random(305, 0);

    configure(1, 255, 16'hFFFF, 16'hFFFF, 1, 0);
    hold_request = 1'b1;
    run_random(150, 80);
    drain();
    run_random(155, 0);

    configure(0, $urandom_range(0, 8), $urandom_range(1, 40), $urandom_range(0, 65535),
              $urandom_range(1, 6), $urandom_range(0, 60));
    run_random(305, 150);

    configure($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(1, 65535),
              $urandom_range(0, 65535), $urandom_range(1, 127), $urandom_range(0, 65535));
    run_random(305, 0);

    configure(1, 2, 5, 3, 3, 20);
    run_random(305, 0);

    configure($urandom_range(0, 1), $urandom_range(0, 6), $urandom_range(1, 12),
              $urandom_range(0, 65535), $urandom_range(1, 4), $urandom_range(0, 30));
    run_random(305, 0);

    drain();
    repeat (8) @(posedge clk);
    if (board.outstanding() != 0) begin
      $error("%0d expected result words never arrived", board.outstanding());
      board.mismatches++;
    end
    $display("Sent %0d ticks to %0d encoders under %0d register settings.",
             ticks_sent, NUM_ENCODERS, settings_used);
    $display("Checked %0d result words, %0d with errors.", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS quadrature_encoder_tracker");
    end else begin
      $display("FAIL quadrature_encoder_tracker");
    end
    $finish;
  end
endmodule
